// ===== src/wsd_pkg.sv =====
package wsd_pkg;

   localparam int MAX_LEDS   = 64;
   localparam int LED_ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int LED_CNT_W  = $clog2(MAX_LEDS + 1);
   localparam int WORD_W     = 24;
   localparam int BIT_POS_W  = 5;
   localparam int TICK_W     = 16;
   localparam int PULSE_W    = 10;
   localparam int COUNT_W    = 7;

   localparam logic [BIT_POS_W-1:0] BITS_PER_LED = BIT_POS_W'(WORD_W);

   // request kinds carried in tuser
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // register indexes of the csr port
   localparam logic [1:0] CSR_SHORT_TICKS = 2'd0;
   localparam logic [1:0] CSR_LONG_TICKS  = 2'd1;
   localparam logic [1:0] CSR_RESET_TICKS = 2'd2;
   localparam logic [1:0] CSR_LED_COUNT   = 2'd3;

   localparam logic [PULSE_W-1:0] SHORT_TICKS_RST = PULSE_W'(40);
   localparam logic [PULSE_W-1:0] LONG_TICKS_RST  = PULSE_W'(80);
   localparam logic [TICK_W-1:0]  RESET_TICKS_RST = TICK_W'(30000);
   localparam logic [COUNT_W-1:0] LED_COUNT_RST   = COUNT_W'(10);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RESET = 2'd1,
      PH_HIGH  = 2'd2,
      PH_LOW   = 2'd3
   } phase_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
      logic request_ignored;
   } rsp_type;

endpackage

// ===== src/wsd_ram.sv =====
module wsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/wsd_rsp_skid.sv =====
module wsd_rsp_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  wsd_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output wsd_pkg::rsp_type out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   wsd_pkg::rsp_type out_data_ff, out_data_in;
   wsd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             take;
   logic             push;

   assign in_ready = ~skid_valid_ff;
   assign take     = out_valid_ff & out_ready;
   assign push     = in_valid & ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== src/ws2812_pixel_line_driver.sv =====
// ws2812 pixel line driver
//
// every req transaction is one clock tick of the led line timing and yields
// exactly one rsp transaction, in order. req_tuser carries the request kind:
// plain tick, pixel write (index and g/r/b levels in req_tdata) or frame start.
// rsp_tdata reports the line level for that tick, the busy flag and the
// refused-request flag; rsp_tlast marks the tick that ends the last bit.
// a start holds the line low for reset_ticks, then sends led_count words of
// 24 bits, green first, msb first; a one is long high / short low.
// the response of a transaction is registered in the rsp skid stage before it shows on rsp.
// throughput: one transaction per cycle sustained while rsp_tready stays high; the frame
// store is a one-port-write, one-port-read ram with a registered read, and the
// next led word is prefetched while the current one is shifted out.
// reset clears the csr registers to their defaults, puts the engine in idle
// and clears the frame store at once through per-entry valid bits (no sweep).
// when the rsp side stalls, one more transaction is taken into a skid stage,
// after that req_tready stays low until the receiver takes a response again.
// csr writes are meant for idle periods and take effect on the next cycle.
module ws2812_pixel_line_driver (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // led_index[5:0], red_level[13:6],
                                   // green_level[21:14], blue_level[29:22], zero
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // line_level[0], busy_res[1],
                                   // request_ignored[2], zero
   output logic        rsp_tlast,  // frame_done
   // csr write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = wsd_pkg::LED_ADDR_W;
   localparam int CW = wsd_pkg::LED_CNT_W;
   localparam int WW = wsd_pkg::WORD_W;
   localparam int TW = wsd_pkg::TICK_W;
   localparam int PW = wsd_pkg::PULSE_W;
   localparam int BW = wsd_pkg::BIT_POS_W;

   // ---------------------------------------------------------------- csr regs
   logic [PW-1:0]                short_ticks_ff;
   logic [PW-1:0]                long_ticks_ff;
   logic [TW-1:0]                reset_ticks_ff;
   logic [wsd_pkg::COUNT_W-1:0]  led_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ticks_ff <= wsd_pkg::SHORT_TICKS_RST;
         long_ticks_ff  <= wsd_pkg::LONG_TICKS_RST;
         reset_ticks_ff <= wsd_pkg::RESET_TICKS_RST;
         led_count_ff   <= wsd_pkg::LED_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            wsd_pkg::CSR_SHORT_TICKS: short_ticks_ff <= csr_wdata[PW-1:0];
            wsd_pkg::CSR_LONG_TICKS:  long_ticks_ff  <= csr_wdata[PW-1:0];
            wsd_pkg::CSR_RESET_TICKS: reset_ticks_ff <= csr_wdata[TW-1:0];
            wsd_pkg::CSR_LED_COUNT:   led_count_ff   <= csr_wdata[wsd_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero counts act as one, led count saturates at the store depth
   logic [PW-1:0] short_len;
   logic [PW-1:0] long_len;
   logic [TW-1:0] reset_len;
   logic [CW-1:0] eff_count;

   assign short_len = (short_ticks_ff == '0) ? PW'(1) : short_ticks_ff;
   assign long_len  = (long_ticks_ff == '0) ? PW'(1) : long_ticks_ff;
   assign reset_len = (reset_ticks_ff == '0) ? TW'(1) : reset_ticks_ff;

   always_comb begin
      if (led_count_ff == '0) begin
         eff_count = CW'(1);
      end else if (led_count_ff > wsd_pkg::MAX_LEDS) begin
         eff_count = CW'(wsd_pkg::MAX_LEDS);
      end else begin
         eff_count = CW'(led_count_ff);
      end
   end

   // ---------------------------------------------------------------- request
   logic       accept;
   logic [1:0] req_type;
   logic [5:0] led_index;
   logic [7:0] red_level;
   logic [7:0] green_level;
   logic [7:0] blue_level;

   assign accept      = req_tvalid & req_tready;
   assign req_type    = req_tuser;
   assign led_index   = req_tdata[5:0];
   assign red_level   = req_tdata[13:6];
   assign green_level = req_tdata[21:14];
   assign blue_level  = req_tdata[29:22];

   // ---------------------------------------------------------------- engine state
   wsd_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [TW-1:0]      tick_ff, tick_in, tick_cur, tick_inc;
   logic [BW-1:0]      bit_pos_ff, bit_pos_in, bit_inc;
   logic [AW-1:0]      led_pos_ff, led_pos_in;
   logic [CW-1:0]      led_inc;
   logic [WW-1:0]      shifter_ff, shifter_in;
   logic [WW-1:0]      word0_ff, word0_in;
   logic [wsd_pkg::MAX_LEDS-1:0] valid_ff, valid_in;

   logic idle;
   logic in_range;
   logic write_ok;
   logic start_ok;
   logic ignored;
   logic one_bit;

   assign idle     = (phase_ff == wsd_pkg::PH_IDLE);
   assign in_range = (led_index < eff_count);
   assign write_ok = (req_type == wsd_pkg::REQ_WRITE) && idle && in_range;
   assign start_ok = (req_type == wsd_pkg::REQ_START) && idle;
   assign ignored  = ((req_type == wsd_pkg::REQ_WRITE) && !(idle && in_range)) ||
                     ((req_type == wsd_pkg::REQ_START) && !idle);

   // a start from idle enters the reset phase on the same tick
   assign phase_cur = start_ok ? wsd_pkg::PH_RESET : phase_ff;
   assign tick_cur  = start_ok ? '0 : tick_ff;
   assign tick_inc  = tick_cur + TW'(1);
   assign bit_inc   = bit_pos_ff + BW'(1);
   assign led_inc   = CW'(led_pos_ff) + CW'(1);
   assign one_bit   = shifter_ff[WW-1];

   logic reset_end;
   logic high_end;
   logic low_end;
   logic bit_last;
   logic led_last;

   assign reset_end = (tick_inc >= reset_len);
   assign high_end  = (tick_inc >= TW'(one_bit ? long_len : short_len));
   assign low_end   = (tick_inc >= TW'(one_bit ? short_len : long_len));
   assign bit_last  = (bit_inc >= wsd_pkg::BITS_PER_LED);
   assign led_last  = (led_inc >= eff_count);

   // ---------------------------------------------------------------- frame store
   // the next led's word is read continuously at led_pos + 1; the store only
   // changes while idle, so the read data is settled long before a word ends.
   // entry zero is mirrored in word0_ff so a frame can start right after a write
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] rd_addr_ff;
   logic [WW-1:0] rd_data;
   logic [WW-1:0] next_word;
   logic [WW-1:0] wr_word;

   assign rd_addr   = led_pos_ff + AW'(1);
   assign wr_word   = {green_level, red_level, blue_level};
   assign next_word = valid_ff[rd_addr_ff] ? rd_data : '0;

   wsd_ram #(
      .WIDTH (WW),
      .DEPTH (wsd_pkg::MAX_LEDS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (accept & write_ok),
      .wr_addr (AW'(led_index)),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
   end

   // ---------------------------------------------------------------- next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_cur)
            wsd_pkg::PH_RESET: if (reset_end) phase_in = wsd_pkg::PH_HIGH;
                               else phase_in = wsd_pkg::PH_RESET;
            wsd_pkg::PH_HIGH:  if (high_end) phase_in = wsd_pkg::PH_LOW;
                               else phase_in = wsd_pkg::PH_HIGH;
            wsd_pkg::PH_LOW: begin
               if (low_end && bit_last && led_last) begin
                  phase_in = wsd_pkg::PH_IDLE;
               end else if (low_end) begin
                  phase_in = wsd_pkg::PH_HIGH;
               end else begin
                  phase_in = wsd_pkg::PH_LOW;
               end
            end
            default: phase_in = wsd_pkg::PH_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath and outputs
   wsd_pkg::rsp_type rsp_now;

   always_comb begin
      tick_in    = tick_ff;
      bit_pos_in = bit_pos_ff;
      led_pos_in = led_pos_ff;
      shifter_in = shifter_ff;
      word0_in   = word0_ff;
      valid_in   = valid_ff;
      rsp_now    = '0;
      rsp_now.request_ignored = ignored;
      if (accept) begin
         if (write_ok) begin
            valid_in[AW'(led_index)] = 1'b1;
            if (led_index == '0) begin
               word0_in = wr_word;
            end
         end
         unique case (phase_cur)
            wsd_pkg::PH_RESET: begin
               rsp_now.busy_res = 1'b1;
               tick_in          = tick_inc;
               if (reset_end) begin
                  tick_in    = '0;
                  led_pos_in = '0;
                  bit_pos_in = '0;
                  shifter_in = word0_ff;
               end
            end
            wsd_pkg::PH_HIGH: begin
               rsp_now.busy_res   = 1'b1;
               rsp_now.line_level = 1'b1;
               tick_in            = high_end ? '0 : tick_inc;
            end
            wsd_pkg::PH_LOW: begin
               rsp_now.busy_res = 1'b1;
               tick_in          = tick_inc;
               if (low_end) begin
                  tick_in    = '0;
                  shifter_in = {shifter_ff[WW-2:0], 1'b0};
                  bit_pos_in = bit_inc;
                  if (bit_last) begin
                     bit_pos_in = '0;
                     if (led_last) begin
                        led_pos_in         = '0;
                        rsp_now.frame_done = 1'b1;
                     end else begin
                        led_pos_in = AW'(led_inc);
                        shifter_in = next_word;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wsd_pkg::PH_IDLE;
         tick_ff    <= '0;
         bit_pos_ff <= '0;
         led_pos_ff <= '0;
         shifter_ff <= '0;
         word0_ff   <= '0;
         valid_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_pos_ff <= bit_pos_in;
         led_pos_ff <= led_pos_in;
         shifter_ff <= shifter_in;
         word0_ff   <= word0_in;
         valid_ff   <= valid_in;
      end
   end

   // ---------------------------------------------------------------- response side
   wsd_pkg::rsp_type rsp_out;
   logic             skid_ready;

   assign req_tready = skid_ready;

   wsd_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (skid_ready),
      .in_data   (rsp_now),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tdata = {5'b0, rsp_out.request_ignored, rsp_out.busy_res, rsp_out.line_level};
   assign rsp_tlast = rsp_out.frame_done;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

class led_line_checker;
   logic [wsd_pkg::WORD_W-1:0]    frame_words [wsd_pkg::MAX_LEDS];
   logic [wsd_pkg::PULSE_W-1:0]   short_len;
   logic [wsd_pkg::PULSE_W-1:0]   long_len;
   logic [wsd_pkg::TICK_W-1:0]    hold_len;
   logic [wsd_pkg::COUNT_W-1:0]   led_total;
   wsd_pkg::phase_type            phase;
   logic [wsd_pkg::TICK_W-1:0]    ticks;
   logic [wsd_pkg::BIT_POS_W-1:0] bit_idx;
   int                            led_idx;
   logic [wsd_pkg::WORD_W-1:0]    shifter;
   wsd_pkg::rsp_type              expected_levels [$];
   int                            failures;
   int                            reported;

   function new();
      foreach (frame_words[i]) frame_words[i] = '0;
      short_len = wsd_pkg::SHORT_TICKS_RST;
      long_len  = wsd_pkg::LONG_TICKS_RST;
      hold_len  = wsd_pkg::RESET_TICKS_RST;
      led_total = wsd_pkg::LED_COUNT_RST;
      phase     = wsd_pkg::PH_IDLE;
      ticks     = '0;
      bit_idx   = '0;
      led_idx   = 0;
      shifter   = '0;
      failures  = 0;
      reported  = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
         wsd_pkg::CSR_SHORT_TICKS: short_len = value[wsd_pkg::PULSE_W-1:0];
         wsd_pkg::CSR_LONG_TICKS:  long_len  = value[wsd_pkg::PULSE_W-1:0];
         wsd_pkg::CSR_RESET_TICKS: hold_len  = value[wsd_pkg::TICK_W-1:0];
         wsd_pkg::CSR_LED_COUNT:   led_total = value[wsd_pkg::COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   function int floor_one(int v);
      return (v == 0) ? 1 : v;
   endfunction

   // zero acts as one, above the store size it saturates
   function int leds_per_frame();
      int n;
      n = floor_one(int'(led_total));
      return (n > wsd_pkg::MAX_LEDS) ? wsd_pkg::MAX_LEDS : n;
   endfunction

   function bit busy();
      return phase != wsd_pkg::PH_IDLE;
   endfunction

   function int pending();
      return expected_levels.size();
   endfunction

   // one accepted request is one tick: request first, then the line engine
   function void accept_request(logic [1:0] kind, logic [5:0] idx,
                                logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      wsd_pkg::rsp_type exp;
      logic             one;
      int               len;
      exp = '0;
      if (kind == wsd_pkg::REQ_WRITE) begin
         if (phase != wsd_pkg::PH_IDLE || int'(idx) >= leds_per_frame())
            exp.request_ignored = 1'b1;
         else
            frame_words[idx] = {green, red, blue};
      end else if (kind == wsd_pkg::REQ_START) begin
         if (phase != wsd_pkg::PH_IDLE) begin
            exp.request_ignored = 1'b1;
         end else begin
            phase = wsd_pkg::PH_RESET;
            ticks = '0;
         end
      end
      one = shifter[wsd_pkg::WORD_W-1];
      case (phase)
         wsd_pkg::PH_RESET: begin
            exp.busy_res = 1'b1;
            ticks = ticks + 1'b1;
            if (int'(ticks) >= floor_one(int'(hold_len))) begin
               ticks   = '0;
               led_idx = 0;
               bit_idx = '0;
               shifter = frame_words[0];
               phase   = wsd_pkg::PH_HIGH;
            end
         end
         wsd_pkg::PH_HIGH: begin
            exp.busy_res   = 1'b1;
            exp.line_level = 1'b1;
            len = floor_one(one ? int'(long_len) : int'(short_len));
            ticks = ticks + 1'b1;
            if (int'(ticks) >= len) begin
               ticks = '0;
               phase = wsd_pkg::PH_LOW;
            end
         end
         wsd_pkg::PH_LOW: begin
            exp.busy_res = 1'b1;
            len = floor_one(one ? int'(short_len) : int'(long_len));
            ticks = ticks + 1'b1;
            if (int'(ticks) >= len) begin
               ticks   = '0;
               shifter = shifter << 1;
               bit_idx = bit_idx + 1'b1;
               phase   = wsd_pkg::PH_HIGH;
               if (int'(bit_idx) >= wsd_pkg::WORD_W) begin
                  bit_idx = '0;
                  led_idx++;
                  if (led_idx >= leds_per_frame()) begin
                     led_idx        = 0;
                     exp.frame_done = 1'b1;
                     phase          = wsd_pkg::PH_IDLE;
                  end else begin
                     shifter = frame_words[led_idx];
                  end
               end
            end
         end
         default: ;
      endcase
      expected_levels.push_back(exp);
   endfunction

   function void flag(string what, wsd_pkg::rsp_type exp, wsd_pkg::rsp_type got);
      failures++;
      if (reported < 10) begin
         reported++;
         $display("mismatch (%s): expected line=%0b busy=%0b done=%0b ignored=%0b,",
                  what, exp.line_level, exp.busy_res, exp.frame_done, exp.request_ignored);
         $display("   got line=%0b busy=%0b done=%0b ignored=%0b",
                  got.line_level, got.busy_res, got.frame_done, got.request_ignored);
      end
   endfunction

   function void check_levels(wsd_pkg::rsp_type got);
      wsd_pkg::rsp_type exp;
      if (expected_levels.size() == 0) begin
         flag("nothing pending", '0, got);
         return;
      end
      exp = expected_levels.pop_front();
      if (got.line_level !== exp.line_level || got.busy_res !== exp.busy_res ||
          got.frame_done !== exp.frame_done || got.request_ignored !== exp.request_ignored)
         flag("field", exp, got);
   endfunction
endclass

module tb_top;
   // request kind that the block must treat as a plain tick
   localparam logic [1:0] REQ_SPARE    = 2'd3;
   localparam int         MAX_CYCLES   = 200_000;
   localparam int         ITEMS        = 400;
   // upper bound on the ticks that a one led frame of the random part can take
   localparam int         FRAME_BUDGET = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   led_line_checker line_check = new();

   wsd_pkg::rsp_type rsp_seen;
   int cycle_count;
   int items_sent;      // every request transaction, ticks included
   int stall_left;
   bit calm;            // phase with no idling on either side
   bit paused_once;

   ws2812_pixel_line_driver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: the limit covers every transaction under the worst idling
   initial begin
      cycle_count = 0;
      while (cycle_count <= MAX_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pause_length();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 80) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side: sample at the rising edge, change tready at the falling edge
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            rsp_seen.line_level      = rsp_tdata[0];
            rsp_seen.busy_res        = rsp_tdata[1];
            rsp_seen.frame_done      = rsp_tlast;
            rsp_seen.request_ignored = rsp_tdata[2];
            line_check.check_levels(rsp_seen);
         end
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            stall_left = pause_length();
         end
      end
   end

   // one request transaction; tvalid stays high on return so back-to-back
   // transactions never lower and raise it in the same step
   task automatic send_item(logic [1:0] kind, logic [5:0] idx,
                            logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      int gap;
      gap = pause_length();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {2'b00, blue, green, red, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      line_check.accept_request(kind, idx, red, green, blue);
      items_sent++;
   endtask

   task automatic send_random(logic [1:0] kind);
      send_item(kind, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // hold the sender off until every pending response has come back
   task automatic wait_for_responses();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (line_check.pending() != 0) @(posedge clock);
   endtask

   task automatic set_register(logic [1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      line_check.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // new settings once the block is idle and nothing is in flight
   task automatic load_settings(logic [15:0] short_w, logic [15:0] long_w,
                                logic [15:0] hold_w, logic [15:0] count_w);
      wait_for_responses();
      repeat (2) @(posedge clock);
      set_register(wsd_pkg::CSR_SHORT_TICKS, short_w);
      set_register(wsd_pkg::CSR_LONG_TICKS, long_w);
      set_register(wsd_pkg::CSR_RESET_TICKS, hold_w);
      set_register(wsd_pkg::CSR_LED_COUNT, count_w);
   endtask

   // tick the engine until the frame is out; now and then a write or start lands
   // while busy and must be refused without disturbing the frame
   task automatic run_frame();
      int ticks_sent;
      int r;
      ticks_sent = 0;
      while (line_check.busy()) begin
         r = $urandom_range(0, 99);
         if (r < 2)      send_random(wsd_pkg::REQ_WRITE);
         else if (r < 4) send_random(wsd_pkg::REQ_START);
         else if (r < 5) send_random(REQ_SPARE);
         else            send_random(wsd_pkg::REQ_TICK);
         ticks_sent++;
         // sender pause in the middle of a frame
         if (ticks_sent == 20 && (!paused_once || $urandom_range(0, 3) == 0)) begin
            paused_once = 1'b1;
            wait_for_responses();
         end
      end
   endtask

   // new settings, some writes, then a one led frame when the budget allows
   task automatic run_frame_phase(logic [15:0] short_w, logic [15:0] long_w,
                                  logic [15:0] hold_w, logic [15:0] count_w, int writes);
      int total;
      int r;
      load_settings(short_w, long_w, hold_w, count_w);
      calm  = ($urandom_range(0, 2) == 0);
      total = line_check.leds_per_frame();
      for (int i = 0; i < writes; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            send_random(wsd_pkg::REQ_TICK);
         end else if (r < 12) begin
            send_random(REQ_SPARE);
         end else begin
            // mostly in range, some anywhere in the index field
            send_item(wsd_pkg::REQ_WRITE,
                      (r < 85) ? 6'($urandom_range(0, total - 1)) : 6'($urandom_range(0, 63)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
         end
      end
      if (total == 1 && items_sent + FRAME_BUDGET <= ITEMS) begin
         send_random(wsd_pkg::REQ_START);
         run_frame();
      end
   endtask

   // random junk above the register width, which the block must drop
   function automatic logic [15:0] with_junk(int value, int width);
      if ($urandom_range(0, 4) == 0)
         return 16'(value) | 16'($urandom_range(0, 65535) << width);
      return 16'(value);
   endfunction

   // tiny timings keep frames short; led count sometimes zero or saturating
   task automatic random_phase();
      int s;
      int l;
      int h;
      int c;
      int r;
      s = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
      l = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
      h = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
      r = $urandom_range(0, 9);
      if (r == 0)      c = 0;
      else if (r == 1) c = $urandom_range(65, 127);
      else if (r == 2) c = $urandom_range(3, 64);
      else             c = $urandom_range(1, 2);
      run_frame_phase(with_junk(s, wsd_pkg::PULSE_W), with_junk(l, wsd_pkg::PULSE_W),
                      16'(h), with_junk(c, wsd_pkg::COUNT_W), $urandom_range(2, 6));
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = wsd_pkg::REQ_TICK;
      csr_we      = 1'b0;
      csr_index   = wsd_pkg::CSR_SHORT_TICKS;
      csr_wdata   = '0;
      calm        = 1'b0;
      paused_once = 1'b0;
      items_sent  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // at the reset settings: edge indexes, refusals and the idle line
      send_item(wsd_pkg::REQ_WRITE, 6'd0, 8'hFF, 8'hFF, 8'hFF);
      send_item(wsd_pkg::REQ_WRITE, 6'd9, 8'hAA, 8'h55, 8'h0F);
      send_item(wsd_pkg::REQ_WRITE, 6'd10, 8'h12, 8'h34, 8'h56);  // just past the led count
      send_item(wsd_pkg::REQ_WRITE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
      send_item(REQ_SPARE, 6'd63, 8'hFF, 8'hFF, 8'hFF);           // unknown kind acts as a tick
      send_item(wsd_pkg::REQ_TICK, 6'd0, 8'h00, 8'h00, 8'h00);    // idle line

      // two leds; zero short and reset ticks act as one
      load_settings(16'd0, 16'd2, 16'd0, 16'd2);
      send_item(wsd_pkg::REQ_WRITE, 6'd0, 8'h0F, 8'hA5, 8'h3C);
      send_item(wsd_pkg::REQ_WRITE, 6'd1, 8'h81, 8'h7E, 8'hC3);
      send_item(wsd_pkg::REQ_WRITE, 6'd2, 8'h12, 8'h34, 8'h56);   // just past the led count
      send_item(wsd_pkg::REQ_START, 6'd0, 8'h00, 8'h00, 8'h00);   // reset phase starts at once
      send_item(wsd_pkg::REQ_WRITE, 6'd1, 8'h80, 8'h01, 8'hC3);   // refused while busy
      send_item(wsd_pkg::REQ_START, 6'd0, 8'h00, 8'h00, 8'h00);   // refused while busy
      send_item(REQ_SPARE, 6'd5, 8'h0F, 8'hF0, 8'h3C);
      run_frame();

      // one led frames back to back; zero led count and pulse ticks act as one
      load_settings(16'd0, 16'd0, 16'd2, 16'hFF80);
      send_item(wsd_pkg::REQ_WRITE, 6'd0, 8'hC0, 8'h03, 8'h99);
      send_item(wsd_pkg::REQ_WRITE, 6'd1, 8'h11, 8'h22, 8'h33);   // past a count of one
      send_item(wsd_pkg::REQ_START, 6'd0, 8'h00, 8'h00, 8'h00);
      run_frame();
      send_item(wsd_pkg::REQ_START, 6'd0, 8'h00, 8'h00, 8'h00);   // first idle tick
      run_frame();

      // led count saturates at the store size
      load_settings(16'd1, 16'd2, 16'd1, 16'd127);
      send_item(wsd_pkg::REQ_WRITE, 6'd63, 8'h5A, 8'hA5, 8'h01);
      send_item(wsd_pkg::REQ_WRITE, 6'd40, 8'h02, 8'h04, 8'h08);
      load_settings(16'd1, 16'd2, 16'd1, 16'hFC40);
      send_item(wsd_pkg::REQ_WRITE, 6'd63, 8'h10, 8'h20, 8'h40);
      load_settings(16'd1, 16'd2, 16'd1, 16'd63);
      send_item(wsd_pkg::REQ_WRITE, 6'd63, 8'h10, 8'h20, 8'h40);  // just past the led count

      while (items_sent < ITEMS) random_phase();

      // drain, then a few more cycles to catch stray transactions
      wait_for_responses();
      repeat (8) @(posedge clock);
      if (line_check.failures == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule

// ===== sim.f =====
src/wsd_pkg.sv
src/wsd_ram.sv
src/wsd_rsp_skid.sv
src/ws2812_pixel_line_driver.sv
sim/tb_top.sv
